FILE: design/dbp_pkg.sv
package dbp_pkg;

    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RESET      = 16'd50;
    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_MS_RESET = 16'd1000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_MS      = 8'd0,
        REG_DOUBLE_WINDOW_MS = 8'd1
    } cfg_index_t;

    // One poll as held in the input register.
    typedef struct packed {
        logic [STAMP_W-1:0] now_ms;
        logic               button_a_level;
        logic               button_b_level;
    } poll_t;

    // One result as computed by the core and held in the result register.
    typedef struct packed {
        logic double_press;
        logic single_press;
        logic pressed_stable;
    } result_t;

    // Handshake between the pipeline stages.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

FILE: design/dbp_input_stage.sv
module dbp_input_stage
    import dbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  poll_t       s_poll,
    input  logic        advance,
    output stage_ctrl_t ctrl,
    output poll_t       poll
);

    logic  valid_reg;
    logic  valid_next;
    poll_t poll_reg;

    // Take a new poll when empty or when the held one moves on this cycle.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            poll_reg <= s_poll;
        end
    end

    assign ctrl.valid   = valid_reg;
    assign ctrl.advance = advance;
    assign poll         = poll_reg;

endmodule

FILE: design/dbp_core.sv
module dbp_core
    import dbp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  stage_ctrl_t            ctrl,
    input  poll_t                  poll,
    output result_t                result
);

    logic [CFG_W-1:0]   debounce_ms_reg;
    logic [CFG_W-1:0]   double_window_ms_reg;
    logic               raw_last_reg;
    logic               stable_level_reg;
    logic               awaiting_second_reg;
    logic [STAMP_W-1:0] change_stamp_reg;
    logic [STAMP_W-1:0] first_press_stamp_reg;

    logic               raw_last_next;
    logic               stable_level_next;
    logic               awaiting_second_next;
    logic [STAMP_W-1:0] change_stamp_next;
    logic [STAMP_W-1:0] first_press_stamp_next;

    logic               raw;
    logic               raw_changed;
    logic [STAMP_W-1:0] since_change;
    logic [STAMP_W-1:0] since_first;
    logic               settle;
    logic               rise;
    logic               in_window;
    logic               update;

    assign update      = ctrl.valid && ctrl.advance;
    assign raw         = !poll.button_a_level || !poll.button_b_level;
    assign raw_changed = raw != raw_last_reg;

    // A raw change restarts the elapsed time at zero, so no settle this poll.
    assign since_change = poll.now_ms - change_stamp_reg;
    assign settle       = !raw_changed && (since_change > {16'd0, debounce_ms_reg})
                          && (raw != stable_level_reg);
    assign rise         = settle && raw;

    assign since_first = poll.now_ms - first_press_stamp_reg;
    assign in_window   = since_first <= {16'd0, double_window_ms_reg};

    always_comb begin
        raw_last_next          = raw;
        change_stamp_next      = raw_changed ? poll.now_ms : change_stamp_reg;
        stable_level_next      = settle ? raw : stable_level_reg;
        awaiting_second_next   = awaiting_second_reg;
        first_press_stamp_next = first_press_stamp_reg;
        result.double_press    = 1'b0;
        result.single_press    = 1'b0;
        if (rise) begin
            if (awaiting_second_reg && in_window) begin
                awaiting_second_next = 1'b0;
                result.double_press  = 1'b1;
            end else begin
                awaiting_second_next   = 1'b1;
                first_press_stamp_next = poll.now_ms;
            end
        end else if (awaiting_second_reg && !in_window) begin
            awaiting_second_next = 1'b0;
            result.single_press  = 1'b1;
        end
        result.pressed_stable = stable_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_last_reg          <= 1'b0;
            stable_level_reg      <= 1'b0;
            awaiting_second_reg   <= 1'b0;
            change_stamp_reg      <= '0;
            first_press_stamp_reg <= '0;
        end else if (update) begin
            raw_last_reg          <= raw_last_next;
            stable_level_reg      <= stable_level_next;
            awaiting_second_reg   <= awaiting_second_next;
            change_stamp_reg      <= change_stamp_next;
            first_press_stamp_reg <= first_press_stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg      <= DEBOUNCE_MS_RESET;
            double_window_ms_reg <= DOUBLE_WINDOW_MS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEBOUNCE_MS:      debounce_ms_reg      <= cfg_data;
                REG_DOUBLE_WINDOW_MS: double_window_ms_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: design/dbp_output_stage.sv
module dbp_output_stage
    import dbp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t result,
    output logic    advance,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Move a result in when the register is empty or its transaction completes.
    assign advance    = in_valid && (!valid_reg || m_ready);
    assign valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: design/button_debounce_double_press.sv
// Debounced double-press detector for two active-low buttons.
//
// Input channel (s_): one poll per transaction, carrying the millisecond time
// stamp and both pin levels. Result channel (m_): one result per poll, with
// the double-press and single-press pulses and the debounced pressed level.
// Configuration channel (cfg_): cfg_index selects debounce_ms (0) or
// double_window_ms (1); other indexes are dropped. Write only while idle.
//
// Path: a poll is held in the input register, passes through the core, and
// its result is held in the result register, which offers it on m_valid.
// Throughput: one poll per cycle while m_ready stays high, set by the single
// pass through the core between the two registers.
//
// Reset: both stages empty, debounce state cleared, registers back to 50 ms
// and 1000 ms. cfg_ready is always high.
//
// Receiver stall: the result register holds its transaction, the input
// register holds one more poll, then s_ready falls until m_ready returns.
module button_debounce_double_press
    import dbp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [STAMP_W-1:0]     s_now_ms,
    input  logic                   s_button_a_level,
    input  logic                   s_button_b_level,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_double_press,
    output logic                   m_single_press,
    output logic                   m_pressed_stable,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    poll_t       s_poll;
    poll_t       poll;
    stage_ctrl_t ctrl;
    result_t     result;
    result_t     m_result;
    logic        advance;

    assign s_poll.now_ms         = s_now_ms;
    assign s_poll.button_a_level = s_button_a_level;
    assign s_poll.button_b_level = s_button_b_level;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    dbp_input_stage u_input (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_poll  (s_poll),
        .advance (advance),
        .ctrl    (ctrl),
        .poll    (poll)
    );

    // State advances only when the held poll moves into the result register.
    dbp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .poll      (poll),
        .result    (result)
    );

    dbp_output_stage u_output (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (ctrl.valid),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_double_press   = m_result.double_press;
    assign m_single_press   = m_result.single_press;
    assign m_pressed_stable = m_result.pressed_stable;

endmodule

FILE: design/dbp_checker.sv
module dbp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_double_press,
    input logic m_single_press,
    input logic m_pressed_stable
);

    // Result register comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_double_press)
        && $stable(m_single_press) && $stable(m_pressed_stable))
        else $error("stalled result changed");

    // Both pulses never in one result.
    a_one_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_double_press && m_single_press))
        else $error("double and single press together");

    // A double press comes from a debounced rising edge.
    a_double_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_double_press |-> m_pressed_stable)
        else $error("double press with button released");

    // An accepted poll leaves a result on offer once it has passed the input and result registers.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("no result two cycles after a poll");

endmodule

bind button_debounce_double_press dbp_checker u_dbp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_double_press   (m_double_press),
    .m_single_press   (m_single_press),
    .m_pressed_stable (m_pressed_stable)
);

FILE: sim/button_debounce_double_press_tb.sv
module button_debounce_double_press_tb
    import dbp_pkg::*;
();

    // Half clock period in time units, run bounds in clock cycles, and the report limit.
    localparam int unsigned HALF_PERIOD  = 10;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned REPORT_MAX   = 10;

    // Register indexes with no register behind them; writes to these must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP   = 8'hFF;

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;

    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic [STAMP_W-1:0]     s_now_ms         = '0;
    logic                   s_button_a_level = 1'b1;
    logic                   s_button_b_level = 1'b1;

    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic                   m_double_press;
    logic                   m_single_press;
    logic                   m_pressed_stable;

    logic                   cfg_valid        = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index        = REG_DEBOUNCE_MS;
    logic [CFG_W-1:0]       cfg_data         = '0;

    button_debounce_double_press u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_now_ms         (s_now_ms),
        .s_button_a_level (s_button_a_level),
        .s_button_b_level (s_button_b_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_double_press   (m_double_press),
        .m_single_press   (m_single_press),
        .m_pressed_stable (m_pressed_stable),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: our own copy of the debounce and window state, plus the
    // register values as last written through the configuration channel.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   debounce_ms    = DEBOUNCE_MS_RESET;
    logic [CFG_W-1:0]   window_ms      = DOUBLE_WINDOW_MS_RESET;
    logic               raw_seen       = 1'b0;
    logic               level_q        = 1'b0;
    logic               window_open    = 1'b0;
    logic [STAMP_W-1:0] change_at_ms   = '0;
    logic [STAMP_W-1:0] first_press_ms = '0;

    poll_t   pending_polls[$];      // polls still to be offered
    result_t expected_presses[$];   // predicted results, oldest first

    function automatic result_t debounce_step(input poll_t p);
        result_t      r;
        logic         raw;
        logic [31:0]  steady_for;
        logic [31:0]  since_first;
        r   = '0;
        raw = !(p.button_a_level && p.button_b_level);
        // A raw change restamps; elapsed is then zero, so no debounce this poll.
        if (raw != raw_seen) begin
            change_at_ms = p.now_ms;
            raw_seen     = raw;
        end
        steady_for  = p.now_ms - change_at_ms;
        since_first = p.now_ms - first_press_ms;
        if (steady_for > {16'd0, debounce_ms} && raw != level_q) begin
            level_q = raw;
            // Only a rising debounced edge touches the window.
            if (raw) begin
                if (window_open && since_first <= {16'd0, window_ms}) begin
                    window_open     = 1'b0;
                    r.double_press  = 1'b1;
                end else begin
                    first_press_ms = p.now_ms;
                    window_open    = 1'b1;
                end
            end
        end
        // Window timeout is checked last, against a possibly restamped window.
        since_first = p.now_ms - first_press_ms;
        if (window_open && since_first > {16'd0, window_ms}) begin
            window_open    = 1'b0;
            r.single_press = 1'b1;
        end
        r.pressed_stable = level_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pacing knobs, set by the stimulus process at the falling edge.
    // ------------------------------------------------------------------
    int unsigned tx_gap_max = 10;
    int unsigned rx_gap_max = 10;
    logic        hold_go    = 1'b0;   // toggle to request one long receiver hold-off

    // ------------------------------------------------------------------
    // Driver: offer queued polls, idling a random number of cycles after
    // each one, and predict the result of every accepted transaction.
    // ------------------------------------------------------------------
    int unsigned tx_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_presses.push_back(
                    debounce_step({s_now_ms, s_button_a_level, s_button_b_level}));
            end
            // Hold the current transaction until it is taken.
            if (!s_valid || s_ready) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (pending_polls.size() != 0) begin
                    {s_now_ms, s_button_a_level, s_button_b_level} <=
                        pending_polls.pop_front();
                    s_valid <= 1'b1;
                    tx_wait = $urandom_range(0, tx_gap_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off on the result side, counted here so that the sender
    // keeps offering polls meanwhile and the block has to stall its input.
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    logic        hold_seen = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_go) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_go;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results with random stalls and compare each one with
    // the oldest prediction.
    // ------------------------------------------------------------------
    int unsigned rx_wait    = 0;
    int unsigned fail_count = 0;
    result_t     want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_presses.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("[%0t] result with nothing expected: %s%0b %s%0b %s%0b",
                                 $realtime, "dbl=", m_double_press, "sgl=",
                                 m_single_press, "lvl=", m_pressed_stable);
                    fail_count++;
                end else begin
                    want = expected_presses.pop_front();
                    if (m_double_press !== want.double_press ||
                        m_single_press !== want.single_press ||
                        m_pressed_stable !== want.pressed_stable) begin
                        if (fail_count < REPORT_MAX)
                            $display("[%0t] mismatch: expected %s%0b %s%0b %s%0b, %s%0b %s%0b %s%0b",
                                     $realtime, "dbl=", want.double_press,
                                     "sgl=", want.single_press,
                                     "lvl=", want.pressed_stable,
                                     "got dbl=", m_double_press,
                                     "sgl=", m_single_press,
                                     "lvl=", m_pressed_stable);
                        fail_count++;
                    end
                end
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [STAMP_W-1:0] clock_ms     = '0;   // time stamp of the next generated poll
    int unsigned        queued_polls = 0;

    task automatic queue_poll(input logic [STAMP_W-1:0] t, input logic a, input logic b);
        pending_polls.push_back({t, a, b});
        queued_polls++;
    endtask

    // Queue one poll at clock_ms with some pin pattern for the given level.
    task automatic push_level(input logic pressed);
        logic a;
        logic b;
        a = 1'b1;
        b = 1'b1;
        if (pressed) begin
            case ($urandom_range(0, 2))
                0:       {a, b} = 2'b00;
                1:       {a, b} = 2'b01;
                default: {a, b} = 2'b10;
            endcase
        end
        queue_poll(clock_ms, a, b);
    endtask

    // Change to a level, then hold it for dur ms, ending exactly at change + dur.
    task automatic hold_level(input logic pressed, input int unsigned dur);
        logic [STAMP_W-1:0] start;
        int unsigned        n;
        clock_ms = clock_ms + $urandom_range(1, 5);
        push_level(pressed);
        start = clock_ms;
        n     = $urandom_range(1, 4);
        for (int unsigned k = 1; k <= n; k++) begin
            clock_ms = start + (dur * k) / n;
            push_level(pressed);
        end
    endtask

    // Contact chatter: a few polls of random levels close together.
    task automatic chatter();
        repeat ($urandom_range(0, 3)) begin
            clock_ms = clock_ms + $urandom_range(0, 3);
            queue_poll(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Noise: random stamps, steps backwards and jumps near the wrap point.
    task automatic noise_burst(input int unsigned win);
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
                0:       clock_ms = $urandom();
                1:       clock_ms = clock_ms - $urandom_range(1, 100);
                default: clock_ms = ~($urandom_range(0, 2 * win + 100));
            endcase
            queue_poll(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic int unsigned around(input int unsigned centre);
        int unsigned d;
        d = $urandom_range(0, 4);
        if ($urandom_range(0, 1) && centre >= d)
            return centre - d;
        return centre + d;
    endfunction

    // One click: chatter, press, chatter, release. Durations sit around
    // the debounce and window limits so that boundaries get hit often.
    task automatic click(input int unsigned deb, input int unsigned win);
        int unsigned press_dur;
        int unsigned release_dur;
        case ($urandom_range(0, 5))
            0:       press_dur = around(deb);
            1:       press_dur = $urandom_range(0, deb);
            default: press_dur = deb + $urandom_range(1, deb / 2 + 20);
        endcase
        case ($urandom_range(0, 5))
            0:       release_dur = around(deb);
            1:       release_dur = around(win);
            2:       release_dur = $urandom_range(win, 2 * win + deb + 50);
            default: release_dur = deb + $urandom_range(1, win / 2 + 10);
        endcase
        chatter();
        hold_level(1'b1, press_dur);
        chatter();
        hold_level(1'b0, release_dur);
    endtask

    // Wait until nothing is queued, offered or expected, then let the pipe settle.
    task automatic wait_drained();
        while (pending_polls.size() != 0 || s_valid || expected_presses.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DEBOUNCE_MS:      debounce_ms = val;
            REG_DOUBLE_WINDOW_MS: window_ms   = val;
            default: ;
        endcase
    endtask

    // Drain, reprogram both registers, then queue a batch of mostly clean
    // clicks with some noise. squeeze requests the long receiver hold-off.
    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] win,
                             input int unsigned n_polls, input int unsigned tx_max,
                             input int unsigned rx_max, input logic squeeze);
        int unsigned target;
        wait_drained();
        write_reg(REG_DEBOUNCE_MS, deb);
        write_reg(REG_DOUBLE_WINDOW_MS, win);
        @(negedge aclk);
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        if (squeeze)
            hold_go = ~hold_go;
        if ($urandom_range(0, 3) == 0)
            clock_ms = $urandom();
        target = queued_polls + n_polls;
        while (queued_polls < target) begin
            if ($urandom_range(0, 9) == 0)
                noise_burst(32'(win));
            else
                click(32'(deb), 32'(win));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed polls at the reset register values (50 ms, 1000 ms).
        queue_poll(32'd0,    1'b1, 1'b1);   // idle, nothing changes
        queue_poll(32'd10,   1'b0, 1'b1);   // raw press on the first pin
        queue_poll(32'd60,   1'b0, 1'b1);   // steady exactly the debounce time: no change
        queue_poll(32'd61,   1'b1, 1'b0);   // one ms more, other pin: first press opens window
        queue_poll(32'd62,   1'b1, 1'b1);   // raw release
        queue_poll(32'd112,  1'b1, 1'b1);
        queue_poll(32'd113,  1'b1, 1'b1);   // falling debounced edge only
        queue_poll(32'd200,  1'b0, 1'b0);   // raw change after a long quiet spell, no debounce yet
        queue_poll(32'd251,  1'b0, 1'b0);   // second press inside window: double
        queue_poll(32'd252,  1'b1, 1'b1);
        queue_poll(32'd303,  1'b1, 1'b1);
        queue_poll(32'd400,  1'b0, 1'b1);
        queue_poll(32'd451,  1'b0, 1'b1);   // new window
        queue_poll(32'd452,  1'b1, 1'b1);
        queue_poll(32'd1451, 1'b1, 1'b1);   // window age equals the limit: still open
        queue_poll(32'd1452, 1'b1, 1'b1);   // one past: single
        queue_poll(32'd2000, 1'b1, 1'b0);
        queue_poll(32'd2051, 1'b1, 1'b0);   // window opens at 2051
        queue_poll(32'd2052, 1'b1, 1'b1);
        queue_poll(32'd2103, 1'b1, 1'b1);
        queue_poll(32'd3000, 1'b0, 1'b0);
        queue_poll(32'd3051, 1'b0, 1'b0);   // exactly the window apart: double
        queue_poll(32'hFFFF_FFF0, 1'b0, 1'b1);  // still pressed, stamp just before the wrap
        queue_poll(32'h0000_0030, 1'b0, 1'b1);  // still pressed past the wrap: no raw change
        queue_poll(32'h0000_0010, 1'b1, 1'b1);  // time steps backwards
        queue_poll(32'h0000_0005, 1'b1, 1'b1);  // reads as a huge interval: the release settles, no window to time out
        clock_ms = 32'h0000_1000;

        // Random phases over a spread of settings, extremes included.
        run_phase(DEBOUNCE_MS_RESET, DOUBLE_WINDOW_MS_RESET, 300, 10, 10, 1'b0);
        run_phase(16'd0,     16'd0,     200, 10, 10, 1'b0);
        run_phase(16'hFFFF,  16'hFFFF,  250, 10, 10, 1'b0);
        run_phase(16'd0,     16'hFFFF,  200, 10, 10, 1'b0);
        run_phase(16'hFFFF,  16'd0,     150, 10, 10, 1'b0);

        // Writes to unmapped indexes must leave both registers alone.
        wait_drained();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_TOP,   16'h0000);

        // Back-to-back stretch with no idling on either side.
        run_phase(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 3000)),
                  250, 0, 0, 1'b0);
        // Sender streams while the receiver holds off: the block must stall its input.
        run_phase(16'd20,    16'd300,   200, 0, 3, 1'b1);
        run_phase(16'd1,     16'd1,     100, 10, 10, 1'b0);
        run_phase(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                  300, 10, 10, 1'b0);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expected_presses.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
design/dbp_pkg.sv
design/dbp_input_stage.sv
design/dbp_core.sv
design/dbp_output_stage.sv
design/button_debounce_double_press.sv
design/dbp_checker.sv
sim/button_debounce_double_press_tb.sv
